/* rtl/core/dqbf_pkg.sv */
package dqbf_pkg;

	localparam int MAX_NAME_LEN    = 256;
	localparam int PATTERN_COUNT   = 3;
	localparam int MAX_PATTERN_LEN = 16;

	localparam int NAME_POS_W = $clog2(MAX_NAME_LEN) + 1;
	localparam int SUM_W      = ((NAME_POS_W > 8) ? NAME_POS_W : 8) + 1;
	localparam int PAT_LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
	localparam int MATCH_W    = 2;

	localparam int CFG_ADDR_W = 3;
	localparam logic REG_DNS_PORT = 1'b0;

	localparam logic [15:0] DNS_PORT_RESET = 16'd53;
	localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
	localparam logic [15:0] PROTO_OFFSET   = 16'd9;
	localparam logic [15:0] DPORT_HI_OFS   = 16'd2;
	localparam logic [15:0] DPORT_LO_OFS   = 16'd3;
	localparam logic [15:0] NAME_START_OFS = 16'd19;
	localparam logic [3:0]  MIN_IHL        = 4'd5;
	localparam logic [7:0]  LABEL_DOT      = 8'h2E;
	localparam logic [MATCH_W-1:0] NO_MATCH = 2'd3;

	localparam logic [MAX_PATTERN_LEN*8-1:0] PATTERN_TEXT [PATTERN_COUNT] = '{
		"blocked.com", "bad.domain", "evil.org"
	};
	localparam logic [PAT_LEN_W-1:0] PATTERN_LEN [PATTERN_COUNT] = '{
		PAT_LEN_W'(11), PAT_LEN_W'(10), PAT_LEN_W'(8)
	};

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_LEN    = 5'b00010,
		PH_LABEL  = 5'b00100,
		PH_DONE   = 5'b01000,
		PH_FAIL   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic               drop;
		logic               is_dns_query;
		logic               name_parsed;
		logic [MATCH_W-1:0] matched_entry;
		logic [7:0]         name_length;
	} result_t;

	// pattern strings are right-justified in the packed table
	function automatic logic [7:0] pattern_char(input int i, input int p);
		int idx;
		idx = int'(PATTERN_LEN[i]) - 1 - p;
		if (idx < 0)
			return 8'h00;
		return PATTERN_TEXT[i][idx*8 +: 8];
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A)
			return c + 8'h20;
		return c;
	endfunction

endpackage

/* rtl/core/dns_query_blocklist_filter.sv */
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   packet_byte[7:0], last_byte
// out       source     out_valid / out_stall drop, is_dns_query, name_parsed,
//                                            matched_entry[1:0], name_length[7:0]
// cfg       APB slave  psel/penable/pready   paddr[2:0], pwdata, prdata (dns_port at 0)
//
// One item per cycle sustained unless a last byte waits on a stalled verdict.
// Each byte is registered, then one pass of compares and counter updates
// against the packet state forms the verdict, which the output register
// takes when the parser consumes the last byte from the input register.
// Reset clears the packet state and loads dns_port with 53.
// A stalled verdict holds in the output register; bytes that carry no verdict
// keep flowing, and only a last byte waits for the output register to free up.
module dns_query_blocklist_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	// byte input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     packet_byte,
	input  logic                           last_byte,
	// verdict output
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           drop,
	output logic                           is_dns_query,
	output logic                           name_parsed,
	output logic [1:0]                     matched_entry,
	output logic [7:0]                     name_length,
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dqbf_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import dqbf_pkg::*;

	logic [15:0] dns_port;
	logic        valid_s1;
	item_t       item_s1;
	logic        consume;
	result_t     result_s2;

	// register file: destination port of DNS queries
	dqbf_apb_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.dns_port (dns_port)
	);

	// input register: hold one byte until the parser takes it
	dqbf_in_reg u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.packet_byte (packet_byte),
		.last_byte   (last_byte),
		.consume     (consume),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1)
	);

	// header checks, label walk, prefix match and verdict register
	dqbf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.dns_port  (dns_port),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.consume   (consume),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.result_s2 (result_s2)
	);

	assign drop          = result_s2.drop;
	assign is_dns_query  = result_s2.is_dns_query;
	assign name_parsed   = result_s2.name_parsed;
	assign matched_entry = result_s2.matched_entry;
	assign name_length   = result_s2.name_length;

endmodule

/* rtl/core/dqbf_apb_regs.sv */
module dqbf_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dqbf_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output logic [15:0]                    dns_port
);
	import dqbf_pkg::*;

	logic [15:0] dns_port_q;
	logic        wr_en;
	logic        reg_idx;

	assign reg_idx = paddr[CFG_ADDR_W-1];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign dns_port = dns_port_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dns_port_q <= DNS_PORT_RESET;
		end else if (wr_en && reg_idx == REG_DNS_PORT) begin
			dns_port_q <= pwdata[15:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DNS_PORT: prdata = {16'd0, dns_port_q};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

/* rtl/core/dqbf_in_reg.sv */
module dqbf_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      packet_byte,
	input  logic            last_byte,
	input  logic            consume,
	output logic            valid_s1,
	output dqbf_pkg::item_t item_s1
);
	import dqbf_pkg::*;

	logic accept;

	assign in_stall = valid_s1 && !consume;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data <= packet_byte;
			item_s1.last <= last_byte;
		end
	end

endmodule

/* rtl/core/dqbf_parser.sv */
module dqbf_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       dns_port,
	input  logic              valid_s1,
	input  dqbf_pkg::item_t   item_s1,
	output logic              consume,
	input  logic              out_stall,
	output logic              out_valid,
	output dqbf_pkg::result_t result_s2
);
	import dqbf_pkg::*;

	phase_t                    phase_q, phase_d;
	logic [15:0]               offset_q, offset_d;
	logic [5:0]                hdr_bytes_q, hdr_bytes_d;
	logic                      udp_seen_q, udp_seen_d;
	logic [7:0]                port_hi_q, port_hi_d;
	logic                      port_hit_q, port_hit_d;
	logic [7:0]                label_left_q, label_left_d;
	logic [NAME_POS_W-1:0]     name_pos_q, name_pos_d;
	logic [PATTERN_COUNT-1:0]  alive_q, alive_d;

	logic                      out_valid_q;
	logic                      out_free;
	logic [7:0]                b;
	logic [15:0]               hdr_ext;
	logic [3:0]                ihl;
	logic                      feed_en;
	logic [7:0]                feed_char;
	logic [SUM_W-1:0]          need_len;
	logic [SUM_W-1:0]          pos_ext;
	logic [PATTERN_COUNT-1:0]  kill;
	logic                      is_dns;
	logic                      parsed;
	logic [MATCH_W-1:0]        match;
	result_t                   res;

	assign b         = item_s1.data;
	assign out_free  = !out_valid_q || !out_stall;
	assign consume   = valid_s1 && (!item_s1.last || out_free);
	assign out_valid = out_valid_q;
	assign hdr_ext   = 16'(hdr_bytes_q);
	assign ihl       = (b[3:0] < MIN_IHL) ? MIN_IHL : b[3:0];
	assign need_len  = SUM_W'(name_pos_q) + SUM_W'(b) + SUM_W'(2);

	// next packet state for the item in the input register
	always_comb begin
		phase_d      = phase_q;
		hdr_bytes_d  = hdr_bytes_q;
		udp_seen_d   = udp_seen_q;
		port_hi_d    = port_hi_q;
		port_hit_d   = port_hit_q;
		label_left_d = label_left_q;
		feed_en      = 1'b0;
		feed_char    = b;
		unique case (phase_q)
			PH_HEADER: begin
				if (offset_q == 16'd0)
					hdr_bytes_d = {ihl, 2'b00};
				if (offset_q == PROTO_OFFSET)
					udp_seen_d = (b == IP_PROTO_UDP);
				if (offset_q == hdr_ext + DPORT_HI_OFS)
					port_hi_d = b;
				if (offset_q == hdr_ext + DPORT_LO_OFS)
					port_hit_d = ({port_hi_q, b} == dns_port);
				if (offset_q == hdr_ext + NAME_START_OFS)
					phase_d = PH_LEN;
			end
			PH_LEN: begin
				if (b == 8'd0) begin
					phase_d = PH_DONE;
				end else if (item_s1.last || need_len > SUM_W'(MAX_NAME_LEN)) begin
					phase_d = PH_FAIL;
				end else begin
					feed_en      = (name_pos_q != '0);
					feed_char    = LABEL_DOT;
					label_left_d = b;
					phase_d      = PH_LABEL;
				end
			end
			PH_LABEL: begin
				if (item_s1.last) begin
					phase_d = PH_FAIL;
				end else begin
					feed_en      = 1'b1;
					label_left_d = label_left_q - 8'd1;
					if (label_left_q == 8'd1)
						phase_d = PH_LEN;
				end
			end
			PH_DONE, PH_FAIL: begin
				phase_d = phase_q;
			end
			default: begin
				phase_d = PH_FAIL;
			end
		endcase

		offset_d = (offset_q != 16'hFFFF) ? offset_q + 16'd1 : offset_q;
	end

	// prefix compare of one name character against every pattern
	always_comb begin
		pos_ext = SUM_W'(name_pos_q);
		for (int i = 0; i < PATTERN_COUNT; i++) begin
			kill[i] = feed_en
				&& pos_ext < SUM_W'(PATTERN_LEN[i])
				&& pos_ext < SUM_W'(MAX_PATTERN_LEN)
				&& fold_case(feed_char) != pattern_char(i, int'(name_pos_q));
		end
		alive_d = alive_q & ~kill;
		if (feed_en && name_pos_q != '1)
			name_pos_d = name_pos_q + NAME_POS_W'(1);
		else
			name_pos_d = name_pos_q;
	end

	// verdict from the state after this item
	always_comb begin
		is_dns = udp_seen_d && port_hit_d && phase_d != PH_HEADER;
		parsed = is_dns && (phase_d == PH_LEN || phase_d == PH_DONE);
		match  = NO_MATCH;
		if (parsed) begin
			for (int i = PATTERN_COUNT - 1; i >= 0; i--) begin
				if (alive_d[i] && SUM_W'(name_pos_d) >= SUM_W'(PATTERN_LEN[i]))
					match = MATCH_W'(i);
			end
		end
		res.drop          = (match != NO_MATCH);
		res.is_dns_query  = is_dns;
		res.name_parsed   = parsed;
		res.matched_entry = match;
		res.name_length   = parsed ? 8'(SUM_W'(name_pos_d)) : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			offset_q     <= 16'd0;
			hdr_bytes_q  <= 6'd0;
			udp_seen_q   <= 1'b0;
			port_hi_q    <= 8'd0;
			port_hit_q   <= 1'b0;
			label_left_q <= 8'd0;
			name_pos_q   <= '0;
			alive_q      <= '1;
		end else if (consume) begin
			if (item_s1.last) begin
				phase_q      <= PH_HEADER;
				offset_q     <= 16'd0;
				hdr_bytes_q  <= 6'd0;
				udp_seen_q   <= 1'b0;
				port_hi_q    <= 8'd0;
				port_hit_q   <= 1'b0;
				label_left_q <= 8'd0;
				name_pos_q   <= '0;
				alive_q      <= '1;
			end else begin
				phase_q      <= phase_d;
				offset_q     <= offset_d;
				hdr_bytes_q  <= hdr_bytes_d;
				udp_seen_q   <= udp_seen_d;
				port_hi_q    <= port_hi_d;
				port_hit_q   <= port_hit_d;
				label_left_q <= label_left_d;
				name_pos_q   <= name_pos_d;
				alive_q      <= alive_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && item_s1.last)
			result_s2 <= res;
	end

endmodule

/* rtl/core/dqbf_checker.sv */
module dqbf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       drop,
	input logic       is_dns_query,
	input logic       name_parsed,
	input logic [1:0] matched_entry,
	input logic [7:0] name_length
);
	import dqbf_pkg::*;

	// hold a stalled verdict
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drop) && $stable(matched_entry)
			&& $stable(name_length) && $stable(name_parsed) && $stable(is_dns_query))
		else $error("stalled verdict changed");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drop == (is_dns_query && name_parsed && matched_entry != NO_MATCH))
		else $error("drop does not follow the match");

	a_unparsed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !name_parsed |-> matched_entry == NO_MATCH && name_length == 8'd0)
		else $error("unparsed name carries a match or length");

	a_parsed_dns: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && name_parsed |-> is_dns_query)
		else $error("name parsed outside a DNS query");

endmodule

bind dns_query_blocklist_filter dqbf_checker u_dqbf_checker (.*);

/* tb/sv/tb_dns_query_blocklist_filter.sv */
module tb_dns_query_blocklist_filter;
	import dqbf_pkg::*;

	// dns_port is register 0; no register is wider than 32 bits, so it sits at byte 0
	localparam logic [CFG_ADDR_W-1:0] DNS_PORT_ADDR = CFG_ADDR_W'(4 * REG_DNS_PORT);
	localparam int SETTLE_CYCLES = 4;     // slack once every verdict has arrived
	localparam int DRAIN_LIMIT   = 20000;
	localparam int RAND_BYTES    = 60;    // random bytes per idle pattern

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  packet_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        drop;
	logic        is_dns_query;
	logic        name_parsed;
	logic [1:0]  matched_entry;
	logic [7:0]  name_length;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	dns_query_blocklist_filter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.packet_byte  (packet_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drop         (drop),
		.is_dns_query (is_dns_query),
		.name_parsed  (name_parsed),
		.matched_entry(matched_entry),
		.name_length  (name_length),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Idle rates in percent: sender gaps between items, receiver stall cycles.
	int idle_pct  = 0;
	int stall_pct = 0;

	int err_cnt     = 0;
	int pkt_cnt     = 0;
	int byte_cnt    = 0;
	int verdict_cnt = 0;
	int drop_cnt    = 0;
	int port_writes = 0;

	// Blocklist prefixes, kept here as plain text for the filter model.
	string blk_text [PATTERN_COUNT] = '{"blocked.com", "bad.domain", "evil.org"};

	// Filter model state: one packet's parse progress plus the port register.
	phase_t      pr_phase;
	logic [15:0] pr_offset;
	logic [5:0]  pr_hdr;
	logic        pr_udp;
	logic [7:0]  pr_port_hi;
	logic        pr_port_hit;
	logic [7:0]  pr_label_left;
	logic [8:0]  pr_name_pos;
	logic [PATTERN_COUNT-1:0] pr_alive;
	logic [15:0] pr_dns_port;

	// Verdicts the filter owes, oldest first.
	result_t verdict_q [$];
	result_t want_v;

	// Packet under construction and scratch space for a dotted name.
	logic [7:0] pkt [$];
	logic [7:0] name_buf [$];

	task automatic clear_packet_state();
		pr_phase      = PH_HEADER;
		pr_offset     = '0;
		pr_hdr        = '0;
		pr_udp        = 1'b0;
		pr_port_hi    = '0;
		pr_port_hit   = 1'b0;
		pr_label_left = '0;
		pr_name_pos   = '0;
		pr_alive      = '1;
	endtask

	// Run one name character past every prefix that is still in the race.
	task automatic name_char_in(input logic [7:0] c);
		logic [7:0] f;
		f = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
		for (int i = 0; i < PATTERN_COUNT; i++)
			if (int'(pr_name_pos) < blk_text[i].len() && pr_name_pos < MAX_PATTERN_LEN
			    && f != blk_text[i][pr_name_pos])
				pr_alive[i] = 1'b0;
		if (pr_name_pos < 9'd511)
			pr_name_pos = pr_name_pos + 9'd1;
	endtask

	// Advance the filter model by one accepted byte; a last byte queues a verdict.
	task automatic predict_byte(input logic [7:0] b, input logic l);
		int off;
		int hlen;
		int sum;
		result_t r;
		off  = int'(pr_offset);
		hlen = int'(pr_hdr);
		case (pr_phase)
			PH_HEADER: begin
				if (off == 0) begin
					// an IHL below the minimum still means a 20-byte header
					hlen   = (b[3:0] < MIN_IHL) ? 4 * int'(MIN_IHL) : 4 * int'(b[3:0]);
					pr_hdr = 6'(hlen);
				end
				if (off == int'(PROTO_OFFSET))
					pr_udp = (b == IP_PROTO_UDP);
				if (off == hlen + int'(DPORT_HI_OFS))
					pr_port_hi = b;
				if (off == hlen + int'(DPORT_LO_OFS))
					pr_port_hit = ({pr_port_hi, b} == pr_dns_port);
				if (off == hlen + int'(NAME_START_OFS))
					pr_phase = PH_LEN;
			end
			PH_LEN: begin
				sum = int'(pr_name_pos) + int'(b) + 2;
				if (b == 8'd0) begin
					pr_phase = PH_DONE;
				end else if (l || sum > MAX_NAME_LEN) begin
					pr_phase = PH_FAIL;
				end else begin
					if (pr_name_pos != 0)
						name_char_in(LABEL_DOT);
					pr_label_left = b;
					pr_phase      = PH_LABEL;
				end
			end
			PH_LABEL: begin
				if (l) begin
					pr_phase = PH_FAIL;
				end else begin
					name_char_in(b);
					pr_label_left = pr_label_left - 8'd1;
					if (pr_label_left == 8'd0)
						pr_phase = PH_LEN;
				end
			end
			default: ;
		endcase
		if (pr_offset != 16'hFFFF)
			pr_offset = pr_offset + 16'd1;
		if (l) begin
			r                = '0;
			r.is_dns_query   = pr_udp && pr_port_hit && (pr_phase != PH_HEADER);
			r.name_parsed    = r.is_dns_query && (pr_phase == PH_LEN || pr_phase == PH_DONE);
			r.matched_entry  = NO_MATCH;
			if (r.name_parsed) begin
				r.name_length = pr_name_pos[7:0];
				// walk down so the lowest matching index wins
				for (int i = PATTERN_COUNT - 1; i >= 0; i--)
					if (pr_alive[i] && int'(pr_name_pos) >= blk_text[i].len())
						r.matched_entry = 2'(i);
			end
			r.drop = (r.matched_entry != NO_MATCH);
			verdict_q.push_back(r);
			clear_packet_state();
		end
	endtask

	task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			err_cnt++;
		end
	endtask

	// Verdict monitor and receiver stall generator. out_stall is read before
	// this edge's update, so the check sees the value the handshake used.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			verdict_cnt++;
			if (drop)
				drop_cnt++;
			if (verdict_q.size() == 0) begin
				$error("verdict with no packet pending: drop=%0d entry=%0d len=%0d",
				       drop, matched_entry, name_length);
				err_cnt++;
			end else begin
				want_v = verdict_q.pop_front();
				check_field("drop",          8'(want_v.drop),          8'(drop));
				check_field("is_dns_query",  8'(want_v.is_dns_query),  8'(is_dns_query));
				check_field("name_parsed",   8'(want_v.name_parsed),   8'(name_parsed));
				check_field("matched_entry", 8'(want_v.matched_entry), 8'(matched_entry));
				check_field("name_length",   want_v.name_length,       name_length);
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Offer one byte, hold it until the filter takes it, then update the model.
	task automatic push_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		packet_byte <= b;
		last_byte   <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_byte(b, l);
		byte_cnt++;
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++)
			push_byte(pkt[i], i == pkt.size() - 1);
		pkt_cnt++;
	endtask

	// Drop valid, wait out every pending verdict, then let the pipeline empty.
	task automatic settle();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (verdict_q.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register loads when pready is seen.
	task automatic cfg_write(input logic [15:0] port);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= DNS_PORT_ADDR;
		pwdata  <= {16'($urandom), port};  // upper bits must be ignored
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		pr_dns_port = port;
		port_writes++;
	endtask

	task automatic cfg_readback();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= DNS_PORT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[15:0] !== pr_dns_port) begin
			$error("dns_port readback: expected %0d, got %0d", pr_dns_port, prdata[15:0]);
			err_cnt++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] rand_letter();
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	// IP header (IHL words, protocol byte), UDP header with the given
	// destination port, and a random 12-byte DNS header.
	task automatic start_packet(input logic [15:0] dport, input logic [7:0] proto,
	                            input logic [3:0] ihl);
		int hlen;
		pkt.delete();
		hlen = (ihl < MIN_IHL) ? 4 * int'(MIN_IHL) : 4 * int'(ihl);
		pkt.push_back({4'h4, ihl});
		for (int i = 1; i < hlen; i++)
			pkt.push_back((i == int'(PROTO_OFFSET)) ? proto : 8'($urandom));
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		pkt.push_back(dport[15:8]);
		pkt.push_back(dport[7:0]);
		repeat (16) pkt.push_back(8'($urandom));
	endtask

	task automatic load_text(input string d);
		name_buf.delete();
		for (int i = 0; i < d.len(); i++)
			name_buf.push_back(d[i]);
	endtask

	// Encode name_buf as length-prefixed labels plus the closing zero.
	// Empty labels are skipped so a stray dot cannot end the name early.
	task automatic add_name_buf();
		int st;
		st = 0;
		for (int i = 0; i <= name_buf.size(); i++)
			if (i == name_buf.size() || name_buf[i] == LABEL_DOT) begin
				if (i > st) begin
					pkt.push_back(8'(i - st));
					for (int k = st; k < i; k++)
						pkt.push_back(name_buf[k]);
				end
				st = i + 1;
			end
		pkt.push_back(8'h00);
	endtask

	// One label of n characters; raw means any byte value, zero included.
	task automatic add_fill_label(input int n, input bit raw);
		pkt.push_back(8'(n));
		repeat (n) pkt.push_back(raw ? 8'($urandom) : rand_letter());
	endtask

	task automatic query(input logic [15:0] dport, input string d);
		start_packet(dport, IP_PROTO_UDP, MIN_IHL);
		load_text(d);
		add_name_buf();
		send_packet();
	endtask

	// Port register: reset value, both extremes, a random value, read back each time.
	task automatic test_config_port();
		logic [15:0] p;
		cfg_readback();
		cfg_write(16'h0000);
		cfg_readback();
		query(16'h0000, "blocked.com");
		query(DNS_PORT_RESET, "blocked.com");
		settle();
		cfg_write(16'hFFFF);
		cfg_readback();
		query(16'hFFFF, "evil.org");
		settle();
		p = 16'($urandom);
		cfg_write(p);
		cfg_readback();
		query(p, "bad.domain");
		settle();
		cfg_write(DNS_PORT_RESET);
	endtask

	// Prefix matching: mixed case, extended, short, near misses.
	task automatic test_name_matching();
		query(DNS_PORT_RESET, "BaD.DoMaIn");
		query(DNS_PORT_RESET, "evil.org.example");
		query(DNS_PORT_RESET, "evil.or");
		query(DNS_PORT_RESET, "BLOCKED.COM[");
		// a zero byte inside a label never matches a prefix character
		start_packet(DNS_PORT_RESET, IP_PROTO_UDP, MIN_IHL);
		pkt.push_back(8'd3);
		pkt.push_back("b");
		pkt.push_back(8'h00);
		pkt.push_back("d");
		load_text("domain");
		add_name_buf();
		send_packet();
		// bytes after the closing zero are ignored, even if they look like labels
		start_packet(DNS_PORT_RESET, IP_PROTO_UDP, MIN_IHL);
		load_text("evil.org");
		add_name_buf();
		pkt.push_back(8'd3);
		repeat (5) pkt.push_back(8'($urandom));
		send_packet();
	endtask

	// Header length, protocol, port and where the packet ends.
	task automatic test_packet_edges();
		query(DNS_PORT_RESET, "");
		start_packet(DNS_PORT_RESET, IP_PROTO_UDP, MIN_IHL);  // ends one byte short of DNS header
		void'(pkt.pop_back());
		send_packet();
		start_packet(DNS_PORT_RESET, IP_PROTO_UDP, MIN_IHL);  // ends on the last DNS header byte
		send_packet();
		start_packet(DNS_PORT_RESET, 8'd6, MIN_IHL);          // TCP, same name
		load_text("blocked.com");
		add_name_buf();
		send_packet();
		query(DNS_PORT_RESET + 16'd1, "blocked.com");
		for (int ihl = 0; ihl < 16; ihl += 15) begin          // 0 (read as 5) and 15
			start_packet(DNS_PORT_RESET, IP_PROTO_UDP, 4'(ihl));
			load_text("bad.domain");
			add_name_buf();
			send_packet();
		end
		start_packet(DNS_PORT_RESET, IP_PROTO_UDP, MIN_IHL);  // last byte is a length byte
		pkt.push_back(8'd3);
		send_packet();
		start_packet(DNS_PORT_RESET, IP_PROTO_UDP, MIN_IHL);  // label runs past the end
		pkt.push_back(8'd10);
		pkt.push_back("a");
		pkt.push_back("b");
		send_packet();
	endtask

	// Name length limit: the longest single label that fits, and one byte more.
	task automatic test_name_limits();
		start_packet(DNS_PORT_RESET, IP_PROTO_UDP, MIN_IHL);
		add_fill_label(254, 1'b1);
		pkt.push_back(8'h00);
		send_packet();
		start_packet(DNS_PORT_RESET, IP_PROTO_UDP, MIN_IHL);
		add_fill_label(255, 1'b1);
		pkt.push_back(8'h00);
		send_packet();
	endtask

	// Random packet: mostly well-formed queries with random names, plus
	// truncated, oversized, misaddressed and pure-noise packets.
	task automatic rand_packet(input logic [15:0] port);
		logic [15:0] dport;
		logic [7:0]  proto;
		logic [3:0]  ihl;
		int kind;
		int n;
		int n0;
		int cut;
		kind  = $urandom_range(99);
		dport = port;
		if ($urandom_range(9) == 0)
			dport = ($urandom_range(1) == 0) ? port + 16'd1 : 16'($urandom);
		proto = ($urandom_range(19) == 0) ? 8'($urandom) : IP_PROTO_UDP;
		ihl   = ($urandom_range(3) == 0) ? 4'($urandom) : MIN_IHL;
		if (kind >= 95) begin
			pkt.delete();
			n = $urandom_range(1, 60);
			repeat (n) pkt.push_back(8'($urandom));
			send_packet();
			return;
		end
		start_packet(dport, proto, ihl);
		n0 = pkt.size();
		if (kind < 40) begin
			// blocklist entry, possibly cut short, altered or extended
			load_text(blk_text[$urandom_range(PATTERN_COUNT - 1)]);
			case ($urandom_range(3))
				0: repeat ($urandom_range(1, 3)) void'(name_buf.pop_back());
				1: name_buf[$urandom_range(name_buf.size() - 1)] = 8'($urandom_range(33, 126));
				2: begin
					name_buf.push_back(LABEL_DOT);
					repeat ($urandom_range(1, 6)) name_buf.push_back(rand_letter());
				end
				default: ;
			endcase
			foreach (name_buf[i])
				if (name_buf[i] >= 8'h61 && name_buf[i] <= 8'h7A && $urandom_range(1) == 0)
					name_buf[i] = name_buf[i] - 8'h20;
			add_name_buf();
		end else if (kind < 65) begin
			repeat ($urandom_range(1, 4)) add_fill_label($urandom_range(1, 12),
			                                             $urandom_range(9) == 0);
			pkt.push_back(8'h00);
		end else if (kind < 75) begin
			// long names around the length limit
			if ($urandom_range(3) == 0)
				add_fill_label($urandom_range(200, 255), 1'b1);
			else
				repeat ($urandom_range(3, 6)) add_fill_label($urandom_range(40, 63), 1'b0);
			pkt.push_back(8'h00);
		end else if (kind < 85) begin
			// truncate somewhere inside the name
			repeat ($urandom_range(1, 3)) add_fill_label($urandom_range(1, 10), 1'b0);
			pkt.push_back(8'h00);
			cut = $urandom_range(n0, pkt.size() - 1);
			while (pkt.size() > cut)
				void'(pkt.pop_back());
		end else begin
			// end inside or right after the headers
			if ($urandom_range(1) == 0)
				pkt.push_back(8'h00);
			cut = $urandom_range(1, pkt.size());
			while (pkt.size() > cut)
				void'(pkt.pop_back());
		end
		if (kind < 75 && $urandom_range(1) == 0)
			repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
		send_packet();
	endtask

	task automatic test_random(input int send_idle, input int recv_stall,
	                           input logic [15:0] port);
		int b0;
		settle();
		cfg_write(port);
		idle_pct  = send_idle;
		stall_pct = recv_stall;
		b0 = byte_cnt;
		while (byte_cnt - b0 < RAND_BYTES)
			rand_packet(port);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		packet_byte = 8'h00;
		last_byte   = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		pr_dns_port = DNS_PORT_RESET;
		clear_packet_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct  = 26;
		stall_pct = 48;
		test_config_port();
		test_name_matching();
		test_packet_edges();
		test_name_limits();
		test_random(26, 48, 16'($urandom));
		test_random(48, 26, 16'hFFFF);
		test_random(0, 0, 16'h0000);
		settle();

		if (verdict_q.size() != 0) begin
			$error("%0d verdicts never arrived", verdict_q.size());
			err_cnt++;
		end
		$display("covered %0d packets (%0d bytes), %0d verdicts seen, %0d of them drops",
		         pkt_cnt, byte_cnt, verdict_cnt, drop_cnt);
		$display("dns_port loaded %0d times, extremes included; both sides idled and stalled",
		         port_writes);
		if (err_cnt == 0)
			$display("tb_dns_query_blocklist_filter OK");
		else
			$display("tb_dns_query_blocklist_filter NOT OK");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("tb_dns_query_blocklist_filter NOT OK");
		$finish;
	end

endmodule
